[design/temd_pkg.sv]
// Package for the tick extender and midnight detector.
// Holds field widths, request and status codes, and the constant-divide helpers.
// No dependencies; every other file of the block imports it.
package temd_pkg;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned TICK_W = 32;
  localparam int unsigned SEC_W  = 32;
  localparam int unsigned TZ_W   = 5;
  localparam int unsigned TS_W   = 64;
  localparam int unsigned STAT_W = 2;

  // Request function codes. The unused code behaves as a timestamp read.
  localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET_REF = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CHECK   = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_NONE     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MIDNIGHT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_UNSET    = 2'd2;

  localparam logic [16:0]      DAY_SEC   = 17'd86400;
  localparam logic [SEC_W-1:0] DAY_SEC_W = 32'd86400;

  // ceil(2^30 / 125): exact quotient for any 23-bit dividend.
  localparam logic [23:0] RECIP_125 = 24'd8589935;
  // ceil(2^35 / 675): exact quotient for any 25-bit dividend.
  localparam logic [25:0] RECIP_675 = 26'd50903317;

  typedef struct packed {
    logic [15:0] q;
    logic [6:0]  r;
  } div125_t;

  // One 16-bit digit of a long division by 125. The incoming remainder is
  // below 125, so the partial dividend fits in 23 bits and the digit in 16.
  function automatic div125_t div125_step(input logic [6:0] rem_in,
                                          input logic [15:0] digit);
    logic [22:0] v;
    logic [46:0] prod;
    logic [22:0] back;
    div125_t     res;
    v     = {rem_in, digit};
    prod  = 47'(v) * 47'(RECIP_125);
    res.q = prod[45:30];
    back  = {7'd0, res.q} * 23'd125;
    res.r = 7'(v - back);
    return res;
  endfunction

endpackage

[design/temd_if.sv]
// Request and response channel interfaces of the tick extender.
// Valid/ready handshake with the payload alongside; depends on temd_pkg.
interface temd_req_if;
  import temd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [FUNC_W-1:0]       func;
  logic [TICK_W-1:0]       tick_ms;
  logic [SEC_W-1:0]        unix_time_sec;
  logic signed [TZ_W-1:0]  tz_offset_hours;

  modport source (output valid, func, tick_ms, unix_time_sec, tz_offset_hours,
                  input ready);
  modport sink (input valid, func, tick_ms, unix_time_sec, tz_offset_hours,
                output ready);
endinterface

interface temd_rsp_if;
  import temd_pkg::*;
  logic              valid;
  logic              ready;
  logic [TS_W-1:0]   timestamp_ms;
  logic [SEC_W-1:0]  current_unix_sec;
  logic [STAT_W-1:0] status;
  logic [SEC_W-1:0]  next_midnight_sec;

  modport source (output valid, timestamp_ms, current_unix_sec, status,
                  next_midnight_sec, input ready);
  modport sink (input valid, timestamp_ms, current_unix_sec, status,
                next_midnight_sec, output ready);
endinterface

[design/tick_extend_midnight_detect_top.sv]
// Top level of the tick extender and local midnight detector.
// Depends on temd_pkg and the channel interfaces in temd_if.sv.
// Requests pass the stage registers and then the result registers; an unread result
// stalls them, else one request per cycle. The depth comes from the divide by 1000,
// done as a shift by three and four 16-bit long-division digits by 125, one per stage.
// Reset (synchronous, active high) clears wrap tracking, the reference, the midnight
// target and all pipeline valid bits; no clearing pass is needed.
module tick_extend_midnight_detect_top (
  input logic      clk,
  input logic      rst,
  temd_req_if.sink req,
  temd_rsp_if.source rsp
);
  import temd_pkg::*;

  // Fields every stage carries through to the result.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TS_W-1:0]   ts;
    logic [SEC_W-1:0]  base;
  } common_t;

  // Architectural state. The wrap counter and the reference are updated as a
  // request is accepted, so the next request already sees them. The midnight
  // target is only read and written in the last stage, in request order.
  logic [SEC_W-1:0]  wrap_count;
  logic [TICK_W-1:0] last_tick;
  logic [SEC_W-1:0]  ref_unix_sec;
  logic [TS_W-1:0]   ref_timestamp_ms;
  logic [SEC_W-1:0]  midnight_target;

  // Pipeline valid bits and per-stage load enables. A stage loads when it is
  // empty or its content moves on, so bubbles are squeezed out and new
  // requests keep flowing into empty stages while a finished result waits at the output.
  logic v1, v2, v3, v4, v5, out_valid;
  logic ld1, ld2, ld3, ld4, ld5, ld6;
  logic req_fire;

  // Stage payloads.
  common_t               c1, c2, c3, c4, c5;
  logic [60:0]           el1;
  logic [47:0]           el2;
  logic [31:0]           el3;
  logic [15:0]           el4;
  logic [6:0]            rem2, rem3, rem4;
  logic [15:0]           qhi4;
  logic [31:0]           q5;
  logic [SEC_W-1:0]      usec1, usec2, usec3;
  logic signed [TZ_W-1:0] tz1, tz2;
  logic [15:0]           q675_2;
  logic [16:0]           local3;
  logic [SEC_W-1:0]      cand4, cand5;

  // Result registers.
  logic [TS_W-1:0]   out_ts;
  logic [SEC_W-1:0]  out_now;
  logic [STAT_W-1:0] out_status;
  logic [SEC_W-1:0]  out_target;

  assign ld6 = !out_valid || rsp.ready;
  assign ld5 = !v5 || ld6;
  assign ld4 = !v4 || ld5;
  assign ld3 = !v3 || ld4;
  assign ld2 = !v2 || ld3;
  assign ld1 = !v1 || ld2;

  assign req.ready = ld1;
  assign req_fire  = req.valid && ld1;

  // ---------------------------------------------------------------------
  // Entry: widen the tick and form the elapsed time since the reference.
  // A set-reference request becomes its own reference, so its elapsed time
  // is zero and its current second is the given unix second.
  // ---------------------------------------------------------------------
  logic [SEC_W-1:0] wrap_next;
  logic [TS_W-1:0]  ts0;
  logic [TS_W-1:0]  elapsed0;
  logic [SEC_W-1:0] base0;
  logic             is_set0;

  assign is_set0   = (req.func == FUNC_SET_REF);
  assign wrap_next = (req.tick_ms < last_tick) ? wrap_count + 32'd1 : wrap_count;
  assign ts0       = {wrap_next, req.tick_ms};
  assign elapsed0  = is_set0 ? '0 : ts0 - ref_timestamp_ms;
  assign base0     = is_set0 ? req.unix_time_sec : ref_unix_sec;

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_count       <= '0;
      last_tick        <= '0;
      ref_unix_sec     <= '0;
      ref_timestamp_ms <= '0;
    end else if (req_fire) begin
      wrap_count <= wrap_next;
      last_tick  <= req.tick_ms;
      if (is_set0) begin
        ref_unix_sec     <= req.unix_time_sec;
        ref_timestamp_ms <= ts0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2 logic: top division digit (13 bits, padded) and the multiply of
  // the unix second's upper 25 bits by the reciprocal of 675. With
  // 86400 = 128 * 675, the second of day is the remainder mod 675 shifted
  // back up by seven bits, plus the low seven bits.
  // ---------------------------------------------------------------------
  div125_t     dA;
  logic [50:0] prod675;

  assign dA      = div125_step(7'd0, {3'd0, el1[60:48]});
  assign prod675 = 51'(usec1[31:7]) * 51'(RECIP_675);

  // Stage 3 logic: second digit, and the local second of day folded back
  // into one day after adding the signed timezone.
  div125_t            dB;
  logic [24:0]        rem675;
  logic [16:0]        day_sec;
  logic signed [18:0] tz_sec;
  logic signed [18:0] local_raw;
  logic signed [18:0] local_fold;

  assign dB        = div125_step(rem2, el2[47:32]);
  assign rem675    = usec2[31:7] - 25'(q675_2) * 25'd675;
  assign day_sec   = {rem675[9:0], usec2[6:0]};
  assign tz_sec    = 19'(tz2) * 19'sd3600;
  assign local_raw = $signed({2'b00, day_sec}) + tz_sec;

  always_comb begin
    if (local_raw < 19'sd0) begin
      local_fold = local_raw + 19'sd86400;
    end else if (local_raw >= 19'sd86400) begin
      local_fold = local_raw - 19'sd86400;
    end else begin
      local_fold = local_raw;
    end
  end

  // Stage 4 logic: third digit, and the candidate target. At exact local
  // midnight the target is the given second itself.
  div125_t     dC;
  logic [16:0] remain;

  assign dC     = div125_step(rem3, el3[31:16]);
  assign remain = (local3 == 17'd0) ? 17'd0 : DAY_SEC - local3;

  // Stage 5 logic: last digit completes the low 32 quotient bits.
  div125_t dD;

  assign dD = div125_step(rem4, el4);

  // ---------------------------------------------------------------------
  // Final stage: current second, midnight compare and target update.
  // ---------------------------------------------------------------------
  logic [SEC_W-1:0]  now5;
  logic [SEC_W-1:0]  target_next;
  logic [STAT_W-1:0] status_next;

  assign now5 = c5.base + q5;

  always_comb begin
    target_next = midnight_target;
    status_next = STAT_NONE;
    case (c5.func)
      FUNC_SET_REF: begin
        target_next = cand5;
      end
      FUNC_CHECK: begin
        if (midnight_target == '0) begin
          status_next = STAT_UNSET;
        end else if (now5 >= midnight_target) begin
          target_next = midnight_target + DAY_SEC_W;
          status_next = STAT_MIDNIGHT;
        end
      end
      default: begin
        target_next = midnight_target;
      end
    endcase
  end

  // Valid bits and architectural target.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1              <= 1'b0;
      v2              <= 1'b0;
      v3              <= 1'b0;
      v4              <= 1'b0;
      v5              <= 1'b0;
      out_valid       <= 1'b0;
      midnight_target <= '0;
    end else begin
      if (ld1) v1 <= req.valid;
      if (ld2) v2 <= v1;
      if (ld3) v3 <= v2;
      if (ld4) v4 <= v3;
      if (ld5) v5 <= v4;
      if (ld6) begin
        out_valid <= v5;
        if (v5) begin
          midnight_target <= target_next;
        end
      end
    end
  end

  // Pipeline payload, no reset needed.
  always_ff @(posedge clk) begin
    if (ld1) begin
      c1.func <= req.func;
      c1.ts   <= ts0;
      c1.base <= base0;
      el1     <= elapsed0[63:3];
      usec1   <= req.unix_time_sec;
      tz1     <= req.tz_offset_hours;
    end
    if (ld2) begin
      c2     <= c1;
      rem2   <= dA.r;
      el2    <= el1[47:0];
      usec2  <= usec1;
      tz2    <= tz1;
      q675_2 <= prod675[50:35];
    end
    if (ld3) begin
      c3     <= c2;
      rem3   <= dB.r;
      el3    <= el2[31:0];
      usec3  <= usec2;
      local3 <= local_fold[16:0];
    end
    if (ld4) begin
      c4    <= c3;
      rem4  <= dC.r;
      qhi4  <= dC.q;
      el4   <= el3[15:0];
      cand4 <= usec3 + {15'd0, remain};
    end
    if (ld5) begin
      c5    <= c4;
      q5    <= {qhi4, dD.q};
      cand5 <= cand4;
    end
    if (ld6) begin
      out_ts     <= c5.ts;
      out_now    <= now5;
      out_status <= status_next;
      out_target <= target_next;
    end
  end

  assign rsp.valid             = out_valid;
  assign rsp.timestamp_ms      = out_ts;
  assign rsp.current_unix_sec  = out_now;
  assign rsp.status            = out_status;
  assign rsp.next_midnight_sec = out_target;

  // A reported midnight must have moved the target forward by one day.
  a_midnight_advance: assert property (@(posedge clk) disable iff (rst)
    (v5 && ld6 && status_next == STAT_MIDNIGHT) |=>
      (midnight_target == $past(midnight_target) + DAY_SEC_W))
    else $error("midnight reported without a one-day target advance");

  // A backward tick on an accepted request counts exactly one wrap.
  a_wrap_count: assert property (@(posedge clk) disable iff (rst)
    (req_fire && req.tick_ms < last_tick) |=>
      (wrap_count == $past(wrap_count) + 32'd1))
    else $error("tick wrap not counted");

  // An unset report always goes with a zero target.
  a_unset_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == STAT_UNSET) |-> (rsp.next_midnight_sec == '0))
    else $error("unset status with a nonzero target");

  // With the output register empty, nothing may hold off a new request.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> req.ready)
    else $error("request stalled while the output is empty");

endmodule
